@@ sv/sliding_window_percentile_check_assert.svh @@
// ============================================================================
// Assertion macros for the sliding window percentile check
// Each macro samples on clk and is switched off while rst is high.
// ============================================================================
`ifndef SLIDING_WINDOW_PERCENTILE_CHECK_ASSERT_SVH
`define SLIDING_WINDOW_PERCENTILE_CHECK_ASSERT_SVH

// Antecedent true in this cycle implies consequent in the next cycle.
`define SWPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Antecedent true implies consequent in the same cycle.
`define SWPC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

@@ sv/swpc_pkg.sv @@
// ============================================================================
// swpc_pkg
// Shared widths, codes and helpers of the sliding window percentile check.
// ============================================================================
`timescale 1ns / 1ps

package swpc_pkg;

  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int EFF_W      = $clog2(DEPTH + 1);
  localparam int SCORE_W    = 32;
  localparam int WIN_W      = 11;
  localparam int SLOT_W     = 10;
  localparam int PCT_W      = 7;
  localparam int RANK_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_W      = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
  localparam int MOD_CNT_W  = $clog2(DIV_W);
  localparam int PROD_W     = EFF_W + PCT_W;
  localparam int PCT_SCALE  = 100;
  localparam int WIN_RESET  = 1024;
  localparam int PCT_RESET  = 5;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_LOG   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PCT    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Clamp a programmed window size into 1..DEPTH.
  function automatic logic [EFF_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
    if (ws == '0) begin
      return EFF_W'(1);
    end else if (ws > DEPTH) begin
      return EFF_W'(DEPTH);
    end else begin
      return EFF_W'(ws);
    end
  endfunction

endpackage

@@ sv/sliding_window_percentile_check.sv @@
// ============================================================================
// sliding_window_percentile_check
// Ring of recent scores held in a chain of cells; ranks a queried score
// against the window and flags it when it falls below a percentile.
// ============================================================================
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  in       | in_valid / in_stall   | op, score (signed Q16.16)
//  out      | out_valid / out_stall | is_low, rank
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A log request's score goes straight into the cell at the write pointer.
//  A query request rotates the whole ring once past the single comparator
//  at cell 0, then the result is formed. A window_size or start_slot write
//  holds the block while the remainder unit reduces the write pointer.
//  Reset clears control state only; the ring holds garbage until logged.
//  A stalled result holds in the output register; log requests still flow.
// ============================================================================
`timescale 1ns / 1ps

module sliding_window_percentile_check (
  input  logic                            clk,
  input  logic                            rst,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic signed [swpc_pkg::SCORE_W-1:0] score,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            is_low,
  output logic [swpc_pkg::RANK_W-1:0]     rank,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  swpc_pkg::state_t state;
  swpc_pkg::state_t state_next;

  logic [swpc_pkg::EFF_W-1:0]    eff;
  logic [swpc_pkg::PCT_W-1:0]    pct;
  logic [swpc_pkg::ADDR_W-1:0]   wp;
  logic [swpc_pkg::SCORE_W-1:0]  score_q;
  logic [swpc_pkg::ADDR_W-1:0]   k;
  logic [swpc_pkg::EFF_W-1:0]    count;

  logic [swpc_pkg::SCORE_W-1:0]  cell_val [swpc_pkg::DEPTH];

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          log_fire;
  logic                          scan_shift;
  logic                          hit;
  logic                          out_load;
  logic                          last_k;
  logic                          is_low_calc;

  logic                          mod_start;
  logic [swpc_pkg::DIV_W-1:0]    mod_dividend;
  logic [swpc_pkg::EFF_W-1:0]    mod_divisor;
  logic                          mod_done;
  logic [swpc_pkg::ADDR_W-1:0]   mod_rem;

  // Hold off items while busy, and while a register write is being offered.
  assign in_stall  = (state != swpc_pkg::ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == swpc_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign log_fire  = in_fire && (op == swpc_pkg::OP_LOG);

  assign last_k = (k == swpc_pkg::ADDR_W'(swpc_pkg::DEPTH - 1));

  // Cell 0 holds entry k during the scan; count it only inside the window.
  assign hit = (swpc_pkg::EFF_W'(k) < eff) &&
               ($signed(cell_val[0]) < $signed(score_q));

  // Exact integer percentile test: 100*rank < threshold*window.
  assign is_low_calc =
    (swpc_pkg::PROD_W'(count) * swpc_pkg::PROD_W'(swpc_pkg::PCT_SCALE)) <
    (swpc_pkg::PROD_W'(pct) * swpc_pkg::PROD_W'(eff));

  // ---------------------------------------------------------------------
  // Ring of cells: cell i hands its value to cell i-1 on every scan cycle.
  // A full revolution of DEPTH shifts puts every entry back in place.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < swpc_pkg::DEPTH; i++) begin : g_cell
    swpc_cell u_cell (
      .clk       (clk),
      .shift     (scan_shift),
      .load      (log_fire && (wp == swpc_pkg::ADDR_W'(i))),
      .shift_in  (cell_val[(i + 1) % swpc_pkg::DEPTH]),
      .load_data (score),
      .value     (cell_val[i])
    );
  end

  // Reduce the write pointer or a new start slot modulo the effective window.
  swpc_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mod_start    = 1'b0;
    mod_dividend = swpc_pkg::DIV_W'(wp);
    mod_divisor  = eff;
    scan_shift   = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      swpc_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          unique case (cfg_index)
            swpc_pkg::REG_WINDOW: begin
              // Refit the current pointer into the new window.
              mod_start    = 1'b1;
              mod_dividend = swpc_pkg::DIV_W'(wp);
              mod_divisor  = swpc_pkg::eff_window(cfg_data[swpc_pkg::WIN_W-1:0]);
              state_next   = swpc_pkg::ST_MOD;
            end
            swpc_pkg::REG_START: begin
              mod_start    = 1'b1;
              mod_dividend = swpc_pkg::DIV_W'(cfg_data[swpc_pkg::SLOT_W-1:0]);
              mod_divisor  = eff;
              state_next   = swpc_pkg::ST_MOD;
            end
            default: begin
              state_next = swpc_pkg::ST_IDLE;
            end
          endcase
        end else if (in_fire && (op == swpc_pkg::OP_QUERY)) begin
          state_next = swpc_pkg::ST_SCAN;
        end
      end
      swpc_pkg::ST_MOD: begin
        if (mod_done) begin
          state_next = swpc_pkg::ST_IDLE;
        end
      end
      swpc_pkg::ST_SCAN: begin
        scan_shift = 1'b1;
        if (last_k) begin
          state_next = swpc_pkg::ST_RESULT;
        end
      end
      swpc_pkg::ST_RESULT: begin
        // Wait for the output register to free up.
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = swpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swpc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Configuration and write pointer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      eff <= swpc_pkg::eff_window(swpc_pkg::WIN_W'(swpc_pkg::WIN_RESET));
      pct <= swpc_pkg::PCT_W'(swpc_pkg::PCT_RESET);
      wp  <= '0;
    end else begin
      if (cfg_fire && (cfg_index == swpc_pkg::REG_WINDOW)) begin
        eff <= swpc_pkg::eff_window(cfg_data[swpc_pkg::WIN_W-1:0]);
      end
      if (cfg_fire && (cfg_index == swpc_pkg::REG_PCT)) begin
        pct <= cfg_data[swpc_pkg::PCT_W-1:0];
      end
      if ((state == swpc_pkg::ST_MOD) && mod_done) begin
        wp <= mod_rem;
      end else if (log_fire) begin
        // Advance and wrap at the window edge.
        if (swpc_pkg::EFF_W'(wp) == eff - 1'b1) begin
          wp <= '0;
        end else begin
          wp <= wp + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Query scan: latch the score, then count one entry per cycle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && (op == swpc_pkg::OP_QUERY)) begin
      score_q <= score;
      k       <= '0;
      count   <= '0;
    end else if (state == swpc_pkg::ST_SCAN) begin
      k     <= k + 1'b1;
      count <= count + swpc_pkg::EFF_W'(hit);
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      is_low <= is_low_calc;
      rank   <= swpc_pkg::RANK_W'(count);
    end
  end

endmodule

@@ sv/swpc_cell.sv @@
// ============================================================================
// swpc_cell
// One ring entry: loads a logged score or takes its neighbor's value on shift.
// ============================================================================
`timescale 1ns / 1ps

module swpc_cell (
  input  logic                         clk,
  input  logic                         shift,
  input  logic                         load,
  input  logic [swpc_pkg::SCORE_W-1:0] shift_in,
  input  logic [swpc_pkg::SCORE_W-1:0] load_data,
  output logic [swpc_pkg::SCORE_W-1:0] value
);

  // Payload only: no reset, contents are undefined until logged.
  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_data;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

@@ sv/swpc_mod.sv @@
// ============================================================================
// swpc_mod
// Restoring remainder unit, one dividend bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module swpc_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [swpc_pkg::DIV_W-1:0]    dividend,
  input  logic [swpc_pkg::EFF_W-1:0]    divisor,
  output logic                          done,
  output logic [swpc_pkg::ADDR_W-1:0]   rem
);

  logic                             busy;
  logic [swpc_pkg::MOD_CNT_W-1:0]   cnt;
  logic [swpc_pkg::EFF_W-1:0]       part;
  logic [swpc_pkg::EFF_W-1:0]       part_next;
  logic [swpc_pkg::DIV_W-1:0]       dvd;
  logic [swpc_pkg::EFF_W-1:0]       dsr;
  logic [swpc_pkg::EFF_W:0]         trial;

  // Bring down the next bit; subtract when it fits.
  always_comb begin
    trial = {part, dvd[swpc_pkg::DIV_W-1]};
    if (trial >= {1'b0, dsr}) begin
      part_next = swpc_pkg::EFF_W'(trial - {1'b0, dsr});
    end else begin
      part_next = swpc_pkg::EFF_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == swpc_pkg::MOD_CNT_W'(swpc_pkg::DIV_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == swpc_pkg::MOD_CNT_W'(swpc_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      part <= part_next;
      dvd  <= {dvd[swpc_pkg::DIV_W-2:0], 1'b0};
    end
  end

  // Remainder is below the divisor, which never exceeds DEPTH.
  assign rem = part[swpc_pkg::ADDR_W-1:0];

endmodule

@@ sv/swpc_checker.sv @@
// ============================================================================
// swpc_checker
// Port-level checks of the sliding window percentile check, bound to the top.
// ============================================================================
`timescale 1ns / 1ps
`include "sliding_window_percentile_check_assert.svh"

module swpc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            op,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            is_low,
  input  logic [swpc_pkg::RANK_W-1:0]     rank,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready
);

  logic query_fire;
  logic log_fire;

  assign query_fire = in_valid && !in_stall && (op == swpc_pkg::OP_QUERY);
  assign log_fire   = in_valid && !in_stall && (op == swpc_pkg::OP_LOG);

  // A stalled result holds.
  `SWPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rank) && $stable(is_low))

  // Rank never exceeds the ring depth.
  `SWPC_ASSERT_NOW(a_rank_range, out_valid, rank <= swpc_pkg::DEPTH)

  // A query occupies the block: no item is taken in the next cycle.
  `SWPC_ASSERT_NEXT(a_query_busy, query_fire, in_stall)

  // A log request never makes a result appear.
  `SWPC_ASSERT_NEXT(a_log_silent, log_fire && !out_valid, !out_valid)

  // Register writes are refused only while items are refused too.
  `SWPC_ASSERT_NOW(a_cfg_busy, !cfg_ready, in_stall)

endmodule

bind sliding_window_percentile_check swpc_checker u_swpc_checker (.*);

@@ verif/testbench.sv @@
// ============================================================================
// testbench - sliding_window_percentile_check
// Drives log and query requests, sets up the window registers between phases,
// and checks every rank result against a predictor of the score ring.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

  // --------------------------------------------------------------------------
  // Run limits
  // --------------------------------------------------------------------------
  // A query request walks the whole ring. A window_size or start_slot write
  // waits while the remainder unit reduces the write pointer.
  localparam int SETTLE_CYC  = swpc_pkg::DIV_W + 8;        // quiet time before a write
  localparam int TAIL_CYC    = swpc_pkg::DEPTH + 16;       // watch for stray results
  localparam int DRAIN_LIMIT = 8 * swpc_pkg::DEPTH + 8000; // longest wait at the end
  localparam int HOLD_CYC    = 5000;             // long hold-off on the result side
  localparam int LIMIT_CYC   = 8000000;          // watchdog
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 20;
  localparam int PRELOAD     = 128;              // entries logged before the phases

  localparam logic [swpc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3; // unmapped index, ignored

  localparam logic [swpc_pkg::SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;
  localparam logic [swpc_pkg::SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;
  localparam logic [swpc_pkg::SCORE_W-1:0] ONE_Q     = 32'h0001_0000; // 1.0 in Q16.16

  typedef struct packed {
    logic                        low;
    logic [swpc_pkg::RANK_W-1:0] rank;
  } ranked_t;

  // One row of the directed table: a register write or a request.
  typedef struct packed {
    logic                            is_cfg;
    logic [swpc_pkg::CFG_IDX_W-1:0]  idx;
    logic [swpc_pkg::CFG_DATA_W-1:0] data;
    logic                            op;
    logic [swpc_pkg::SCORE_W-1:0]    score;
    logic                            typed;  // expected result typed in below
    ranked_t                         want;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic                              op;
  logic signed [swpc_pkg::SCORE_W-1:0] score;
  logic                              out_valid;
  logic                              out_stall;
  logic                              is_low;
  logic [swpc_pkg::RANK_W-1:0]       rank;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [swpc_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [swpc_pkg::CFG_DATA_W-1:0]   cfg_data;

  sliding_window_percentile_check dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .score     (score),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_low    (is_low),
    .rank      (rank),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a copy of the ring, its write pointer and the registers
  // --------------------------------------------------------------------------
  logic signed [swpc_pkg::SCORE_W-1:0] ring_copy [0:swpc_pkg::DEPTH-1];
  bit                        ring_loaded [0:swpc_pkg::DEPTH-1]; // written since reset
  int                        wr_ptr;
  logic [swpc_pkg::WIN_W-1:0]  win_reg;
  logic [swpc_pkg::SLOT_W-1:0] slot_reg;
  logic [swpc_pkg::PCT_W-1:0]  pct_reg;

  ranked_t  ranks_due [$];   // ranks still owed by the block, oldest first
  ranked_t  seen_want;
  dir_row_t dir_rows [$];
  int       mismatches;
  bit       hold_req;        // ask the result side for one long hold-off

  // Window length actually in use: zero counts as one, saturate at DEPTH.
  function automatic int active_len();
    if (win_reg == '0) return 1;
    if (int'(win_reg) > swpc_pkg::DEPTH) return swpc_pkg::DEPTH;
    return int'(win_reg);
  endfunction

  // A query may only cover entries that were logged since reset.
  function automatic bit window_loaded();
    int n;
    n = active_len();
    for (int i = 0; i < n; i++) begin
      if (!ring_loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_reg(input logic [swpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swpc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      swpc_pkg::REG_WINDOW: begin
        win_reg = val[swpc_pkg::WIN_W-1:0];
        wr_ptr  = wr_ptr % active_len();
      end
      swpc_pkg::REG_START: begin
        slot_reg = val[swpc_pkg::SLOT_W-1:0];
        wr_ptr   = int'(slot_reg) % active_len();
      end
      swpc_pkg::REG_PCT: begin
        pct_reg = val[swpc_pkg::PCT_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // Log: store the score and advance the pointer. Query: count the entries in
  // the window strictly below the score and compare 100*rank with
  // threshold*window.
  task automatic rank_request(input logic op_i,
                              input logic signed [swpc_pkg::SCORE_W-1:0] sc,
                              output bit produced, output ranked_t res);
    int n;
    int below;
    n        = active_len();
    produced = 1'b0;
    res      = '0;
    if (wr_ptr >= n) wr_ptr = wr_ptr % n;
    if (op_i == swpc_pkg::OP_LOG) begin
      ring_copy[wr_ptr]   = sc;
      ring_loaded[wr_ptr] = 1'b1;
      wr_ptr              = (wr_ptr + 1) % n;
    end else begin
      below = 0;
      for (int i = 0; i < n; i++) begin
        if (ring_copy[i] < sc) below++;
      end
      produced = 1'b1;
      res.low  = (swpc_pkg::PCT_SCALE * below < int'(pct_reg) * n);
      res.rank = below[swpc_pkg::RANK_W-1:0];
    end
  endtask

  // --------------------------------------------------------------------------
  // Random choices
  // --------------------------------------------------------------------------
  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 100);
  endfunction

  // Extremes, a small pool of whole values that produces ties, and raw words.
  function automatic logic [swpc_pkg::SCORE_W-1:0] log_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0:       return SCORE_MIN;
        1:       return SCORE_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 50) return (swpc_pkg::SCORE_W'($urandom_range(0, 15)) - 32'd8) << 16;
    return $urandom;
  endfunction

  // Hit stored values exactly and one step off, so ties land on both sides.
  function automatic logic [swpc_pkg::SCORE_W-1:0] query_score();
    int r;
    int slot;
    r    = $urandom_range(0, 99);
    slot = $urandom_range(0, active_len() - 1);
    if (r < 30) return ring_copy[slot];
    if (r < 40) return ring_copy[slot] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
    return log_score();
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Present one request at the falling edge and hold it until taken. Valid
  // stays high afterwards so that a following request can go back-to-back.
  task automatic send_request(input logic op_i, input logic [swpc_pkg::SCORE_W-1:0] sc,
                              input bit typed, input ranked_t typed_res);
    bit      taken;
    bit      produced;
    ranked_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= op_i;
    score    <= sc;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    rank_request(op_i, sc, produced, res);
    if (produced) ranks_due.push_back(typed ? typed_res : res);
  endtask

  // Drop valid for a gap of length n; zero keeps the request stream going.
  task automatic rest_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_results();
    while (ranks_due.size() != 0) @(posedge clk);
  endtask

  // Stop sending, let every owed result arrive, then let the block settle so
  // that a trailing log request or pointer reduction has finished.
  task automatic quiesce();
    rest_sender(1);
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swpc_pkg::CFG_DATA_W-1:0] val);
    bit taken;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
    end
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick new register values for a phase: mostly small windows, with the
  // extremes and raw 11-bit words mixed in.
  task automatic retune();
    logic [swpc_pkg::CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = swpc_pkg::CFG_DATA_W'($urandom_range(1, 16));
      5, 6:          v = swpc_pkg::CFG_DATA_W'($urandom_range(17, 128));
      7:             v = swpc_pkg::CFG_DATA_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = swpc_pkg::CFG_DATA_W'(1);
          2:       v = swpc_pkg::CFG_DATA_W'(swpc_pkg::DEPTH);
          default: v = '1;
        endcase
      end
    endcase
    write_reg(swpc_pkg::REG_WINDOW, v);
    if ($urandom_range(0, 9) < 7) begin
      write_reg(swpc_pkg::REG_START, swpc_pkg::CFG_DATA_W'($urandom));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = swpc_pkg::CFG_DATA_W'(swpc_pkg::PCT_SCALE);
        2:       v = swpc_pkg::CFG_DATA_W'(127);
        3:       v = swpc_pkg::CFG_DATA_W'($urandom);
        default: v = swpc_pkg::CFG_DATA_W'($urandom_range(0, 100));
      endcase
      write_reg(swpc_pkg::REG_PCT, v);
    end
  endtask

  // One random phase. A query goes out only once the window is fully logged.
  task automatic run_phase(input int count, input int query_pct, input bit burst,
                           input bit pause_midway);
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) begin
        rest_sender(1);
        wait_results();
      end
      if (window_loaded() && $urandom_range(0, 99) < query_pct)
        send_request(swpc_pkg::OP_QUERY, query_score(), 1'b0, '0);
      else
        send_request(swpc_pkg::OP_LOG, log_score(), 1'b0, '0);
      rest_sender(pick_gap(burst));
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  task automatic add_cfg(input logic [swpc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [swpc_pkg::CFG_DATA_W-1:0] val);
    dir_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = val;
    dir_rows.push_back(row);
  endtask

  task automatic add_req(input logic op_i, input logic [swpc_pkg::SCORE_W-1:0] sc,
                         input bit typed, input logic low,
                         input logic [swpc_pkg::RANK_W-1:0] rk);
    dir_row_t row;
    row           = '0;
    row.op        = op_i;
    row.score     = sc;
    row.typed     = typed;
    row.want.low  = low;
    row.want.rank = rk;
    dir_rows.push_back(row);
  endtask

  task automatic build_table();
    // Four-entry window holding the extremes, threshold 50 (bound 200).
    add_cfg(swpc_pkg::REG_WINDOW, 11'd4);
    add_cfg(swpc_pkg::REG_START, 11'd0);
    add_cfg(swpc_pkg::REG_PCT, 11'd50);
    add_cfg(REG_SPARE, 11'h7FF);
    add_req(swpc_pkg::OP_LOG, SCORE_MIN, 0, 0, 0);
    add_req(swpc_pkg::OP_LOG, SCORE_MAX, 0, 0, 0);
    add_req(swpc_pkg::OP_LOG, '0, 0, 0, 0);
    add_req(swpc_pkg::OP_LOG, '1, 0, 0, 0);
    add_req(swpc_pkg::OP_QUERY, SCORE_MIN, 1, 1'b1, 11'd0);
    add_req(swpc_pkg::OP_QUERY, SCORE_MAX, 1, 1'b0, 11'd3);
    // 100*2 equals the bound: not low
    add_req(swpc_pkg::OP_QUERY, '0, 1, 1'b0, 11'd2);
    add_req(swpc_pkg::OP_QUERY, 32'd1, 0, 0, 0);
    add_req(swpc_pkg::OP_QUERY, '1, 1, 1'b1, 11'd1);
    // Threshold zero never flags; above 100 it always flags.
    add_cfg(swpc_pkg::REG_PCT, 11'd0);
    add_req(swpc_pkg::OP_QUERY, SCORE_MAX, 1, 1'b0, 11'd3);
    add_cfg(swpc_pkg::REG_PCT, 11'h7FF);
    add_req(swpc_pkg::OP_QUERY, SCORE_MAX, 1, 1'b1, 11'd3);
    // Window size zero acts as a single entry.
    add_cfg(swpc_pkg::REG_WINDOW, 11'd0);
    add_req(swpc_pkg::OP_QUERY, SCORE_MAX, 1, 1'b1, 11'd1);
    // Upper data bits are dropped: this sets the threshold to 100.
    add_cfg(swpc_pkg::REG_PCT, 11'h764);
    add_req(swpc_pkg::OP_QUERY, SCORE_MAX, 1, 1'b0, 11'd1);
    add_req(swpc_pkg::OP_QUERY, SCORE_MIN, 1, 1'b1, 11'd0);
    add_req(swpc_pkg::OP_LOG, ONE_Q, 0, 0, 0);
    add_req(swpc_pkg::OP_QUERY, '0, 0, 0, 0);
    // Start slot with bit 10 set, then shrink the window under the pointer.
    add_cfg(swpc_pkg::REG_WINDOW, 11'd3);
    add_cfg(swpc_pkg::REG_START, 11'h402);
    add_req(swpc_pkg::OP_LOG, 32'hDEAD_BEEF, 0, 0, 0);
    add_req(swpc_pkg::OP_LOG, 32'h0005_0000, 0, 0, 0);
    add_req(swpc_pkg::OP_LOG, 32'h0007_0000, 0, 0, 0);
    add_cfg(swpc_pkg::REG_WINDOW, 11'd2);
    add_req(swpc_pkg::OP_QUERY, 32'h0006_0000, 0, 0, 0);
    add_req(swpc_pkg::OP_LOG, 32'hFFFD_0000, 0, 0, 0);
    add_req(swpc_pkg::OP_QUERY, 32'h0006_0000, 0, 0, 0);
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYC) begin
      @(posedge clk);
      cycles++;
    end
    $display("sliding_window_percentile_check verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall runs, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int  run;
    bit  stalling;
    out_stall = 1'b0;
    run       = 0;
    stalling  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // Hold off long enough for the block to back up into its input.
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
        run      = 0;
      end else begin
        if (run == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          if (stalling)
            run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 100);
          else
            run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                               : $urandom_range(50, 400);
        end
        out_stall <= stalling;
        run--;
      end
    end
  end

  // Compare each accepted result with the oldest rank owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (ranks_due.size() == 0) begin
        $error("result with no query outstanding: is_low %0d rank %0d", is_low, rank);
        mismatches++;
      end else begin
        seen_want = ranks_due.pop_front();
        if (is_low !== seen_want.low) begin
          $error("is_low mismatch: expected %0d, got %0d", seen_want.low, is_low);
          mismatches++;
        end
        if (rank !== seen_want.rank) begin
          $error("rank mismatch: expected %0d, got %0d", seen_want.rank, rank);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t row;
    int       waited;
    logic [swpc_pkg::SCORE_W-1:0] sc;

    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = swpc_pkg::OP_QUERY;
    score      = '0;
    cfg_valid  = 1'b0;
    cfg_index  = swpc_pkg::REG_WINDOW;
    cfg_data   = '0;
    hold_req   = 1'b0;
    mismatches = 0;
    wr_ptr     = 0;
    win_reg    = swpc_pkg::WIN_W'(swpc_pkg::WIN_RESET);
    slot_reg   = '0;
    pct_reg    = swpc_pkg::PCT_W'(swpc_pkg::PCT_RESET);
    for (int i = 0; i < swpc_pkg::DEPTH; i++) begin
      ring_copy[i]   = '0;
      ring_loaded[i] = 1'b0;
    end

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table; register writes only with the block idle.
    build_table();
    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.is_cfg) begin
        quiesce();
        write_reg(row.idx, row.data);
      end else begin
        send_request(row.op, row.score, row.typed, row.want);
        rest_sender(pick_gap(1'b0));
      end
    end

    // Load a wider window, keeping every entry below the top score so that a
    // query of the top score ranks at the full window.
    quiesce();
    write_reg(swpc_pkg::REG_WINDOW, swpc_pkg::CFG_DATA_W'(PRELOAD));
    write_reg(swpc_pkg::REG_PCT, 11'd127);
    write_reg(swpc_pkg::REG_START, swpc_pkg::CFG_DATA_W'($urandom));
    for (int k = 0; k < PRELOAD; k++) begin
      sc = log_score();
      if (sc == SCORE_MAX) sc = SCORE_MAX - 1;
      send_request(swpc_pkg::OP_LOG, sc, 1'b0, '0);
      rest_sender(pick_gap(k % 64 < 32));
    end
    send_request(swpc_pkg::OP_QUERY, SCORE_MAX, 1'b0, '0);
    rest_sender(pick_gap(1'b0));
    send_request(swpc_pkg::OP_QUERY, SCORE_MIN, 1'b0, '0);
    rest_sender(pick_gap(1'b0));
    send_request(swpc_pkg::OP_QUERY, query_score(), 1'b0, '0);

    // Random phases with fresh register settings each time.
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      retune();
      if (p == 2) begin
        // Back up the block: long result hold-off against a query-heavy stream
        // over a small window that is already logged.
        write_reg(swpc_pkg::REG_WINDOW, swpc_pkg::CFG_DATA_W'(8));
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS, 80, 1'b1, 1'b0);
      end else begin
        run_phase(PHASE_ITEMS, $urandom_range(20, 70), (p % 5) == 3, p == 4);
      end
    end

    // Drain, then watch a while longer for stray results.
    rest_sender(1);
    waited = 0;
    while (ranks_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (ranks_due.size() != 0) begin
      $error("%0d query results never arrived", ranks_due.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("sliding_window_percentile_check verification clean");
    end else begin
      $display("sliding_window_percentile_check verification failed");
    end
    $finish;
  end

endmodule
